>>> design/memory_pattern_test_sequencer_assert.svh
// Assertion macros used by the checker file mpts_checker.sv.
`ifndef MEMORY_PATTERN_TEST_SEQUENCER_ASSERT_SVH
`define MEMORY_PATTERN_TEST_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MPTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/mpts_pkg.sv
`default_nettype none
package mpts_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 17;
	localparam int PHASE_W = 6;

	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [DATA_W-1:0] data_t;

	// Phase plan
	localparam phase_t PH_PAT_A      = 6'd0;
	localparam phase_t PH_PAT_B      = 6'd1;
	localparam phase_t PH_WALK1_FIRST = 6'd2;
	localparam phase_t PH_WALK1_LAST = 6'd17;
	localparam phase_t PH_WALK0_FIRST = 6'd18;
	localparam phase_t PH_WALK0_LAST = 6'd33;
	localparam phase_t PH_INDEX      = 6'd34;
	localparam phase_t PH_LAST       = 6'd35;

	localparam data_t PAT_A = 32'h33cc33cc;
	localparam data_t PAT_B = 32'hcc33cc33;

	// Memory access codes
	typedef enum logic [1:0] {
		ACC_NONE  = 2'd0,
		ACC_WRITE = 2'd1,
		ACC_READ  = 2'd2
	} access_t;

	// Reported test status codes
	typedef enum logic [1:0] {
		STAT_IDLE    = 2'd0,
		STAT_RUNNING = 2'd1,
		STAT_PASSED  = 2'd2,
		STAT_FAILED  = 2'd3
	} status_t;

	// Sequencer state, one-hot
	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_RUNNING = 4'b0010,
		S_PASSED  = 4'b0100,
		S_FAILED  = 4'b1000
	} state_t;

endpackage
`default_nettype wire

>>> design/mpts_in_if.sv
`default_nettype none
interface mpts_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] read_data;

	modport source (output valid, mode, read_data, input ready);
	modport sink (input valid, mode, read_data, output ready);
endinterface
`default_nettype wire

>>> design/mpts_out_if.sv
`default_nettype none
interface mpts_out_if #(
	parameter int ADDR_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           access;
	logic [ADDR_BITS-1:0] address;
	logic [31:0]          write_data;
	logic [1:0]           status;
	logic [5:0]           phase;
	logic [ADDR_BITS-1:0] fail_address;
	logic [31:0]          fail_expected;
	logic [31:0]          fail_got;

	modport source (output valid, access, address, write_data, status, phase,
		fail_address, fail_expected, fail_got, input ready);
	modport sink (input valid, access, address, write_data, status, phase,
		fail_address, fail_expected, fail_got, output ready);
endinterface
`default_nettype wire

>>> design/mpts_pattern.sv
`default_nettype none
module mpts_pattern #(
	parameter int ADDR_BITS = 16
) (
	input  wire mpts_pkg::phase_t        phase,
	input  wire logic [ADDR_BITS-1:0]    index,
	output mpts_pkg::data_t              pattern
);

	mpts_pkg::phase_t one_sh;
	mpts_pkg::phase_t zero_sh;
	logic [15:0]      one_m;
	logic [15:0]      zero_m;
	mpts_pkg::data_t  idx_w;

	// Walking bit positions, valid only inside their phase ranges
	assign one_sh  = phase - mpts_pkg::PH_WALK1_FIRST;
	assign zero_sh = phase - mpts_pkg::PH_WALK0_FIRST;
	assign one_m   = 16'd1 << one_sh[3:0];
	assign zero_m  = 16'd1 << zero_sh[3:0];
	assign idx_w   = mpts_pkg::DATA_W'(index);

	// Select the data word for this phase
	always_comb begin
		if (phase == mpts_pkg::PH_PAT_A) begin
			pattern = mpts_pkg::PAT_A;
		end else if (phase == mpts_pkg::PH_PAT_B) begin
			pattern = mpts_pkg::PAT_B;
		end else if (phase <= mpts_pkg::PH_WALK1_LAST) begin
			pattern = {one_m, one_m};
		end else if (phase <= mpts_pkg::PH_WALK0_LAST) begin
			pattern = ~{zero_m, zero_m};
		end else if (phase == mpts_pkg::PH_INDEX) begin
			pattern = idx_w;
		end else begin
			pattern = ~idx_w;
		end
	end

endmodule
`default_nettype wire

>>> design/mpts_ctrl.sv
`default_nettype none
module mpts_ctrl #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mpts_pkg::COUNT_W-1:0]  cfg_wdata,
	input  wire logic                          fire,
	input  wire logic                          mode,
	input  wire mpts_pkg::data_t               read_data,
	output mpts_pkg::access_t                  res_access,
	output logic [ADDR_BITS-1:0]               res_address,
	output mpts_pkg::data_t                    res_write_data,
	output mpts_pkg::status_t                  res_status,
	output mpts_pkg::phase_t                   res_phase,
	output logic [ADDR_BITS-1:0]               res_fail_address,
	output mpts_pkg::data_t                    res_fail_expected,
	output mpts_pkg::data_t                    res_fail_got
);

	localparam int IDX_W = ADDR_BITS + 1;
	localparam int CMP_W = (IDX_W > mpts_pkg::COUNT_W) ? IDX_W : mpts_pkg::COUNT_W;
	localparam logic [CMP_W-1:0] MAX_WORDS = CMP_W'(1) << ADDR_BITS;
	localparam int RST_COUNT = (ADDR_BITS >= 16) ? 65536 : (1 << ADDR_BITS);

	logic [IDX_W-1:0]     count_q;
	logic [CMP_W-1:0]     cfg_ext;
	logic [IDX_W-1:0]     cfg_clamped;

	mpts_pkg::phase_t     phase_q, phase_n;
	logic                 reading_q, reading_n;
	logic [IDX_W-1:0]     index_q, index_n;
	logic [IDX_W-1:0]     index_inc;
	logic                 pend_q, pend_n;
	logic [ADDR_BITS-1:0] pend_addr_q, pend_addr_n;
	mpts_pkg::data_t      pend_exp_q, pend_exp_n;
	mpts_pkg::state_t     state_q, state_n;
	logic [ADDR_BITS-1:0] fail_addr_q, fail_addr_n;
	mpts_pkg::data_t      fail_exp_q, fail_exp_n;
	mpts_pkg::data_t      fail_got_q, fail_got_n;
	mpts_pkg::data_t      pattern;
	logic [ADDR_BITS-1:0] cur_addr;

	// Clamp the word count once, at write time
	assign cfg_ext = CMP_W'(cfg_wdata);
	always_comb begin
		if (cfg_ext == '0) begin
			cfg_clamped = IDX_W'(1);
		end else if (cfg_ext > MAX_WORDS) begin
			cfg_clamped = IDX_W'(MAX_WORDS);
		end else begin
			cfg_clamped = IDX_W'(cfg_ext);
		end
	end

	assign cur_addr  = index_q[ADDR_BITS-1:0];
	assign index_inc = index_q + IDX_W'(1);

	mpts_pattern #(.ADDR_BITS(ADDR_BITS)) u_pattern (
		.phase   (phase_q),
		.index   (cur_addr),
		.pattern (pattern)
	);

	// Compare the pending read, then issue the next access
	always_comb begin
		phase_n        = phase_q;
		reading_n      = reading_q;
		index_n        = index_q;
		pend_n         = pend_q;
		pend_addr_n    = pend_addr_q;
		pend_exp_n     = pend_exp_q;
		state_n        = state_q;
		fail_addr_n    = fail_addr_q;
		fail_exp_n     = fail_exp_q;
		fail_got_n     = fail_got_q;
		res_access     = mpts_pkg::ACC_NONE;
		res_address    = '0;
		res_write_data = '0;
		if (mode) begin
			phase_n     = '0;
			reading_n   = 1'b0;
			index_n     = '0;
			pend_n      = 1'b0;
			pend_addr_n = '0;
			pend_exp_n  = '0;
			fail_addr_n = '0;
			fail_exp_n  = '0;
			fail_got_n  = '0;
			state_n     = mpts_pkg::S_RUNNING;
		end else if (state_q == mpts_pkg::S_RUNNING) begin
			pend_n = 1'b0;
			if (pend_q && (read_data != pend_exp_q)) begin
				fail_addr_n = pend_addr_q;
				fail_exp_n  = pend_exp_q;
				fail_got_n  = read_data;
				state_n     = mpts_pkg::S_FAILED;
			end else if ((phase_q == mpts_pkg::PH_LAST) && reading_q &&
					(index_q >= count_q)) begin
				state_n = mpts_pkg::S_PASSED;
			end else begin
				res_address = cur_addr;
				if (!reading_q) begin
					res_access     = mpts_pkg::ACC_WRITE;
					res_write_data = pattern;
				end else begin
					res_access  = mpts_pkg::ACC_READ;
					pend_n      = 1'b1;
					pend_addr_n = cur_addr;
					pend_exp_n  = pattern;
				end
				index_n = index_inc;
				if (index_inc >= count_q) begin
					if (!reading_q) begin
						reading_n = 1'b1;
						index_n   = '0;
					end else if (phase_q != mpts_pkg::PH_LAST) begin
						reading_n = 1'b0;
						index_n   = '0;
						phase_n   = phase_q + mpts_pkg::phase_t'(1);
					end
				end
			end
		end
	end

	// Map the one-hot state to its reported code
	always_comb begin
		case (state_n)
			mpts_pkg::S_IDLE:    res_status = mpts_pkg::STAT_IDLE;
			mpts_pkg::S_RUNNING: res_status = mpts_pkg::STAT_RUNNING;
			mpts_pkg::S_PASSED:  res_status = mpts_pkg::STAT_PASSED;
			mpts_pkg::S_FAILED:  res_status = mpts_pkg::STAT_FAILED;
			default:             res_status = mpts_pkg::STAT_IDLE;
		endcase
	end

	assign res_phase         = mode ? '0 : phase_q;
	assign res_fail_address  = fail_addr_n;
	assign res_fail_expected = fail_exp_n;
	assign res_fail_got      = fail_got_n;

	// Hold the sequencer state; advance on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= IDX_W'(RST_COUNT);
			phase_q     <= '0;
			reading_q   <= 1'b0;
			index_q     <= '0;
			pend_q      <= 1'b0;
			pend_addr_q <= '0;
			pend_exp_q  <= '0;
			state_q     <= mpts_pkg::S_IDLE;
			fail_addr_q <= '0;
			fail_exp_q  <= '0;
			fail_got_q  <= '0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_clamped;
			end
			if (fire) begin
				phase_q     <= phase_n;
				reading_q   <= reading_n;
				index_q     <= index_n;
				pend_q      <= pend_n;
				pend_addr_q <= pend_addr_n;
				pend_exp_q  <= pend_exp_n;
				state_q     <= state_n;
				fail_addr_q <= fail_addr_n;
				fail_exp_q  <= fail_exp_n;
				fail_got_q  <= fail_got_n;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/mpts_skid.sv
`default_nettype none
module mpts_skid #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);

	logic             out_valid_q;
	logic [WIDTH-1:0] out_data_q;
	logic             skid_valid_q;
	logic [WIDTH-1:0] skid_data_q;
	logic             in_fire;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: drain the skid word first, park a word when stalled
	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (in_fire) begin
				out_data_q <= in_data;
			end
		end else if (in_fire) begin
			skid_data_q <= in_data;
		end
	end

endmodule
`default_nettype wire

>>> design/memory_pattern_test_sequencer.sv
// Memory pattern test sequencer.
// The req channel carries one word per tick: mode (1 starts a new test, 0 advances
// one tick) and read_data, the memory data for the read issued on the previous tick.
// For each accepted word the rsp channel returns exactly one word: the memory access
// to issue (none, write or read) with its address and write data, the test status,
// the phase and the record of the first miscompare.
// A test runs 36 phases, each a write pass then a read-and-compare pass over
// word_count words; word_count is set through word_count_we/word_count_wdata, and
// the user must write it only while the block is idle, which the block does not
// enforce. Values of zero or above the memory size are clamped.
// Throughput: one word per cycle while rsp does not stall; the sequencer state, the
// pattern generator and the compare are combinational between the state and response registers.
// When rsp stalls, one more word is parked in a skid register and req.ready then
// drops until the stall clears; no word is lost or repeated.
// Reset (arst_n low) clears the sequencer to idle with word_count at the memory size
// (capped at 65536) and empties the response registers.
`default_nettype none
module memory_pattern_test_sequencer #(
	parameter int ADDR_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          word_count_we,
	input  wire logic [mpts_pkg::COUNT_W-1:0]  word_count_wdata,
	mpts_in_if.sink                            req,
	mpts_out_if.source                         rsp
);

	localparam int RES_W = 2 + ADDR_BITS + 32 + 2 + mpts_pkg::PHASE_W + ADDR_BITS + 32 + 32;

	mpts_pkg::access_t    res_access;
	logic [ADDR_BITS-1:0] res_address;
	mpts_pkg::data_t      res_write_data;
	mpts_pkg::status_t    res_status;
	mpts_pkg::phase_t     res_phase;
	logic [ADDR_BITS-1:0] res_fail_address;
	mpts_pkg::data_t      res_fail_expected;
	mpts_pkg::data_t      res_fail_got;
	logic [RES_W-1:0]     res_word;
	logic [RES_W-1:0]     rsp_word;
	logic                 req_fire;

	assign req_fire = req.valid && req.ready;

	mpts_ctrl #(.ADDR_BITS(ADDR_BITS)) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (word_count_we),
		.cfg_wdata         (word_count_wdata),
		.fire              (req_fire),
		.mode              (req.mode),
		.read_data         (req.read_data),
		.res_access        (res_access),
		.res_address       (res_address),
		.res_write_data    (res_write_data),
		.res_status        (res_status),
		.res_phase         (res_phase),
		.res_fail_address  (res_fail_address),
		.res_fail_expected (res_fail_expected),
		.res_fail_got      (res_fail_got)
	);

	// Pack the response word
	assign res_word = {res_access, res_address, res_write_data, res_status, res_phase,
		res_fail_address, res_fail_expected, res_fail_got};

	mpts_skid #(.WIDTH(RES_W)) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_data   (res_word),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_data  (rsp_word)
	);

	// Unpack onto the response channel
	assign {rsp.access, rsp.address, rsp.write_data, rsp.status, rsp.phase,
		rsp.fail_address, rsp.fail_expected, rsp.fail_got} = rsp_word;

endmodule
`default_nettype wire

>>> design/mpts_checker.sv
`default_nettype none
`include "memory_pattern_test_sequencer_assert.svh"
module mpts_checker #(
	parameter int ADDR_BITS = 16
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire logic [1:0]           rsp_access,
	input wire logic [ADDR_BITS-1:0] rsp_address,
	input wire logic [31:0]          rsp_write_data,
	input wire logic [1:0]           rsp_status,
	input wire logic [ADDR_BITS-1:0] rsp_fail_address,
	input wire logic [31:0]          rsp_fail_expected,
	input wire logic [31:0]          rsp_fail_got
);

	// Backpressure on req only ever comes from a full response side
	`MPTS_ASSERT_NOW(a_ready_low_only_when_full, clk, arst_n, !req_ready, rsp_valid, "req.ready low with rsp empty")

	// An access is only issued while the test runs
	`MPTS_ASSERT_NOW(a_access_only_running, clk, arst_n, rsp_valid && (rsp_access != 2'd0), (rsp_status == 2'd1) && (rsp_access == 2'd1 || rsp_access == 2'd2), "access issued outside a running test")

	// Unused fields are zero: no address without access, no write data on a read
	`MPTS_ASSERT_NOW(a_unused_zero, clk, arst_n, rsp_valid && (rsp_access != 2'd1), (rsp_write_data == 32'd0) && ((rsp_access != 2'd0) || (rsp_address == '0)), "unused response field not zero")

	// The fail record stays clear unless the test failed
	`MPTS_ASSERT_NOW(a_fail_record_clear, clk, arst_n, rsp_valid && (rsp_status != 2'd3), (rsp_fail_address == '0) && (rsp_fail_expected == 32'd0) && (rsp_fail_got == 32'd0), "fail record set without failure")

	// A stalled response word holds
	`MPTS_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_access) && $stable(rsp_address) && $stable(rsp_status), "stalled response changed")

endmodule

bind memory_pattern_test_sequencer mpts_checker #(.ADDR_BITS(ADDR_BITS)) u_mpts_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_access        (rsp.access),
	.rsp_address       (rsp.address),
	.rsp_write_data    (rsp.write_data),
	.rsp_status        (rsp.status),
	.rsp_fail_address  (rsp.fail_address),
	.rsp_fail_expected (rsp.fail_expected),
	.rsp_fail_got      (rsp.fail_got)
);
`default_nettype wire
